@@ rtl/sri_pkg.sv @@
// Shared widths, limits, sequencer states and divider request/response types
// for the strided range intersection core. No dependencies.
package sri_pkg;

  localparam int BoundW    = 32;
  localparam int StrideW   = 9;
  localparam int LcmW      = 17;
  localparam int IdxW      = BoundW + 2;
  localparam int DivW      = BoundW + 1;
  localparam int DivCntW   = $clog2(DivW);
  localparam int MaxStride = 256;
  localparam int LcmLimit  = 65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD_START,
    S_GCD_WAIT,
    S_QUO_START,
    S_QUO_WAIT,
    S_LCM,
    S_RES_START,
    S_RES_WAIT,
    S_PSM_START,
    S_PSM_WAIT,
    S_SEARCH,
    S_UPB_START,
    S_UPB_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DivW-1:0]    dividend;
    logic [LcmW-1:0]    divisor;
    logic [DivCntW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
    logic [LcmW-1:0] remainder;
  } div_rsp_t;

endpackage

@@ rtl/sri_sec_if.sv @@
// Input channel: one beat carries two strided sections.
// Depends on sri_pkg for field widths.
interface sri_sec_if;
  import sri_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [BoundW-1:0] first_lower;
  logic signed [BoundW-1:0] first_upper;
  logic [StrideW-1:0]       first_stride;
  logic signed [BoundW-1:0] second_lower;
  logic signed [BoundW-1:0] second_upper;
  logic [StrideW-1:0]       second_stride;

  modport source (
    output valid, first_lower, first_upper, first_stride,
    output second_lower, second_upper, second_stride,
    input  ready
  );

  modport sink (
    input  valid, first_lower, first_upper, first_stride,
    input  second_lower, second_upper, second_stride,
    output ready
  );
endinterface

@@ rtl/sri_res_if.sv @@
// Output channel: one beat carries the intersected section.
// Depends on sri_pkg for field widths.
interface sri_res_if;
  import sri_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     is_empty;
  logic signed [BoundW-1:0] result_lower;
  logic signed [BoundW-1:0] result_upper;
  logic [LcmW-1:0]          result_stride;

  modport source (
    output valid, is_empty, result_lower, result_upper, result_stride,
    input  ready
  );

  modport sink (
    input  valid, is_empty, result_lower, result_upper, result_stride,
    output ready
  );
endinterface

@@ rtl/strided_range_intersection_core.sv @@
// Strided range intersection: sequencer around one shared iterative divider.
// The divider (one bit a cycle) and the search loop (one partner element a cycle,
//   at most the reference stride, 256, steps) set the run time of an item; an
//   invalid stride goes straight to emit. One item at a time.
// Reset (rst, synchronous): sequencer idle, no result pending. Uses sri_pkg, sri_div.
module strided_range_intersection_core (
  input  logic      clk,
  input  logic      rst,
  sri_sec_if.sink   sections,
  sri_res_if.source result
);
  import sri_pkg::*;

  state_t state;
  state_t state_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // reference section (smaller lower bound), partner section, smaller upper
  logic signed [BoundW-1:0] rl;
  logic signed [BoundW-1:0] pl;
  logic signed [BoundW-1:0] minu;
  logic [StrideW-1:0]       rs;
  logic [StrideW-1:0]       ps;
  logic [StrideW-1:0]       sa;
  logic [StrideW-1:0]       sb;
  // Euclid operands
  logic [StrideW-1:0]       ga;
  logic [StrideW-1:0]       gb;
  logic [StrideW-1:0]       quo9;
  logic [LcmW-1:0]          lcm;
  // search state: residue of (idx - rl) mod rs, partner stride mod rs, step
  logic [StrideW-1:0]       res;
  logic [StrideW-1:0]       psm;
  logic [StrideW-1:0]       k;
  logic signed [IdxW-1:0]   idx;
  logic signed [BoundW-1:0] upper;
  logic                     empty;

  logic                     accept;
  logic                     swap;
  logic                     stride_bad;
  logic [2*StrideW-1:0]     lcm_prod;
  logic [StrideW:0]         res_sum;
  logic [StrideW:0]         res_wrap;
  logic signed [DivW-1:0]   d0;
  logic signed [IdxW-1:0]   minu_x;
  logic signed [IdxW-1:0]   diff_up;
  logic                     search_fail;
  logic                     emit_go;

  assign accept = sections.valid && sections.ready;
  assign sections.ready = (state == S_IDLE);

  // the first section is the reference on equal lower bounds
  assign swap = sections.first_lower > sections.second_lower;
  assign stride_bad = (sections.first_stride == '0) ||
                      (sections.first_stride > StrideW'(MaxStride)) ||
                      (sections.second_stride == '0) ||
                      (sections.second_stride > StrideW'(MaxStride));

  assign lcm_prod = quo9 * sb;
  assign d0       = DivW'(pl) - DivW'(rl);
  assign minu_x   = IdxW'(minu);
  assign diff_up  = minu_x - idx;
  assign res_sum  = {1'b0, res} + {1'b0, psm};
  assign res_wrap = (res_sum >= {1'b0, rs}) ? res_sum - {1'b0, rs} : res_sum;

  // stop on: search budget spent, or partner element past the smaller upper
  assign search_fail = (k >= rs) || (idx > minu_x);
  assign emit_go     = !result.valid || result.ready;

  sri_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req    = '0;
    case (state)
      S_IDLE: begin
        if (sections.valid) begin
          state_next = stride_bad ? S_EMIT : S_GCD_START;
        end
      end
      S_GCD_START: begin
        if (gb == '0) begin
          state_next = S_QUO_START;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DivW'(ga);
          div_req.divisor  = LcmW'(gb);
          div_req.nbits    = DivCntW'(StrideW);
          state_next       = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_GCD_START;
        end
      end
      S_QUO_START: begin
        // first stride over gcd, then times second stride gives the lcm
        div_req.start    = 1'b1;
        div_req.dividend = DivW'(sa);
        div_req.divisor  = LcmW'(ga);
        div_req.nbits    = DivCntW'(StrideW);
        state_next       = S_QUO_WAIT;
      end
      S_QUO_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_LCM;
        end
      end
      S_LCM: begin
        state_next = (lcm_prod > (2*StrideW)'(LcmLimit)) ? S_EMIT : S_RES_START;
      end
      S_RES_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = DivW'(d0);
        div_req.divisor  = LcmW'(rs);
        div_req.nbits    = DivCntW'(DivW);
        state_next       = S_RES_WAIT;
      end
      S_RES_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_PSM_START;
        end
      end
      S_PSM_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = DivW'(ps);
        div_req.divisor  = LcmW'(rs);
        div_req.nbits    = DivCntW'(StrideW);
        state_next       = S_PSM_WAIT;
      end
      S_PSM_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (search_fail) begin
          state_next = S_EMIT;
        end else if (res == '0) begin
          state_next = S_UPB_START;
        end
      end
      S_UPB_START: begin
        // remainder of (minu - lower) / lcm trims the upper bound
        div_req.start    = 1'b1;
        div_req.dividend = diff_up[DivW-1:0];
        div_req.divisor  = lcm;
        div_req.nbits    = DivCntW'(DivW);
        state_next       = S_UPB_WAIT;
      end
      S_UPB_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath registers, advanced by sequencer state
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          rl    <= swap ? sections.second_lower : sections.first_lower;
          pl    <= swap ? sections.first_lower : sections.second_lower;
          rs    <= swap ? sections.second_stride : sections.first_stride;
          ps    <= swap ? sections.first_stride : sections.second_stride;
          minu  <= (sections.first_upper < sections.second_upper) ?
                   sections.first_upper : sections.second_upper;
          sa    <= sections.first_stride;
          sb    <= sections.second_stride;
          ga    <= sections.first_stride;
          gb    <= sections.second_stride;
          k     <= '0;
          empty <= stride_bad;
        end
      end
      S_GCD_WAIT: begin
        if (div_rsp.done) begin
          ga <= gb;
          gb <= div_rsp.remainder[StrideW-1:0];
        end
      end
      S_QUO_WAIT: begin
        if (div_rsp.done) begin
          quo9 <= div_rsp.quotient[StrideW-1:0];
        end
      end
      S_LCM: begin
        lcm   <= lcm_prod[LcmW-1:0];
        empty <= lcm_prod > (2*StrideW)'(LcmLimit);
      end
      S_RES_WAIT: begin
        if (div_rsp.done) begin
          res <= div_rsp.remainder[StrideW-1:0];
          idx <= IdxW'(pl);
        end
      end
      S_PSM_WAIT: begin
        if (div_rsp.done) begin
          psm <= div_rsp.remainder[StrideW-1:0];
        end
      end
      S_SEARCH: begin
        if (search_fail) begin
          empty <= 1'b1;
        end else if (res != '0) begin
          // advance to the next partner element
          idx <= idx + IdxW'(ps);
          res <= res_wrap[StrideW-1:0];
          k   <= k + StrideW'(1);
        end
      end
      S_UPB_WAIT: begin
        if (div_rsp.done) begin
          upper <= minu - BoundW'(div_rsp.remainder);
        end
      end
      default: begin
      end
    endcase
  end

  // output register: hold the beat until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      result.is_empty      <= empty;
      result.result_lower  <= empty ? '0 : idx[BoundW-1:0];
      result.result_upper  <= empty ? '0 : upper;
      result.result_stride <= empty ? '0 : lcm;
    end
  end
endmodule

@@ rtl/sri_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, with a per-request
// bit count. Depends on sri_pkg for widths and request/response types.
module sri_div (
  input  logic             clk,
  input  logic             rst,
  input  sri_pkg::div_req_t req,
  output sri_pkg::div_rsp_t rsp
);
  import sri_pkg::*;

  logic               busy;
  logic               done;
  logic [DivCntW-1:0] cnt;
  logic [DivW-1:0]    dvd;
  logic [LcmW-1:0]    dvs;
  logic [LcmW-1:0]    part;
  logic [DivW-1:0]    quo;

  logic [LcmW:0]      shifted;
  logic [LcmW+1:0]    trial;
  logic               borrow;

  assign shifted = {part, dvd[cnt]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};
  assign borrow  = trial[LcmW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend;
      dvs  <= req.divisor;
      cnt  <= req.nbits - DivCntW'(1);
      part <= '0;
      quo  <= '0;
    end else if (busy) begin
      // keep the partial remainder when the trial subtract borrows
      part <= borrow ? shifted[LcmW-1:0] : trial[LcmW-1:0];
      quo  <= {quo[DivW-2:0], ~borrow};
      cnt  <= cnt - DivCntW'(1);
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = part;
endmodule

@@ rtl/sri_checker.sv @@
// Port-level checker for strided_range_intersection_core, attached by bind.
// Depends on sri_pkg for widths.
module sri_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             sec_valid,
  input logic                             sec_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic                             res_is_empty,
  input logic signed [sri_pkg::BoundW-1:0] res_lower,
  input logic signed [sri_pkg::BoundW-1:0] res_upper,
  input logic [sri_pkg::LcmW-1:0]          res_stride
);
  import sri_pkg::*;

  // one item at a time: input closes right after a beat is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sec_valid && sec_ready) |=> !sec_ready)
    else $error("input ready stayed high after an accepted beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_is_empty) |->
      (res_lower == '0 && res_upper == '0 && res_stride == '0))
    else $error("empty result with nonzero fields");

  a_nonempty_order: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_is_empty) |->
      (res_stride != '0 && res_upper >= res_lower))
    else $error("nonempty result with zero stride or upper below lower");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      ($stable(res_is_empty) && $stable(res_lower) &&
       $stable(res_upper) && $stable(res_stride)))
    else $error("result payload changed while stalled");
endmodule

bind strided_range_intersection_core sri_checker u_sri_checker (
  .clk          (clk),
  .rst          (rst),
  .sec_valid    (sections.valid),
  .sec_ready    (sections.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_is_empty (result.is_empty),
  .res_lower    (result.result_lower),
  .res_upper    (result.result_upper),
  .res_stride   (result.result_stride)
);

@@ tb/tb.sv @@
// Self-checking testbench for strided_range_intersection_core: directed and
// random section pairs, with a built-in intersection predictor and a result checker.
// Depends on sri_pkg, sri_sec_if, sri_res_if and the core itself.
`timescale 1ns / 100ps

module tb;
  import sri_pkg::*;

  // One input beat: two strided sections, bounds kept as raw 32-bit patterns.
  typedef struct packed {
    logic [BoundW-1:0]  first_lower;
    logic [BoundW-1:0]  first_upper;
    logic [StrideW-1:0] first_stride;
    logic [BoundW-1:0]  second_lower;
    logic [BoundW-1:0]  second_upper;
    logic [StrideW-1:0] second_stride;
  } section_pair_t;

  // One output beat: the intersected section.
  typedef struct packed {
    logic              is_empty;
    logic [BoundW-1:0] lower;
    logic [BoundW-1:0] upper;
    logic [LcmW-1:0]   stride;
  } intersection_t;

  localparam longint BoundMax = 64'sd2147483647;
  localparam longint BoundMin = -64'sd2147483648;

  logic clk;
  logic rst;

  sri_sec_if sections ();
  sri_res_if result ();

  strided_range_intersection_core dut (
    .clk      (clk),
    .rst      (rst),
    .sections (sections),
    .result   (result)
  );

  // Expected intersections in acceptance order, oldest at the front.
  intersection_t pending_intersections[$];
  int unsigned   failures;
  bit            idling_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far above the slowest legal run (1400 random beats plus the
  // directed ones, gaps and stalls included) taken several times over.
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Pick the section with the smaller lower bound as the reference
  // (first section on a tie), walk the partner's elements for at most
  // reference-stride steps, and take the first one that lands on the
  // reference grid. Stride is the lcm; the upper bound is the last lcm step
  // that stays within the smaller upper bound. Anything else yields empty
  // with all other fields zero.
  // ---------------------------------------------------------------------------
  function automatic intersection_t intersect_sections(section_pair_t s);
    longint        fl, fu, fs, sl, su, ss;
    longint        ref_lo, ref_str, part_lo, part_str, min_up;
    longint        a, b, rem, lcm, idx, top, k;
    intersection_t r;
    r = '0;
    r.is_empty = 1'b1;
    fl = longint'($signed(s.first_lower));
    fu = longint'($signed(s.first_upper));
    fs = longint'(s.first_stride);
    sl = longint'($signed(s.second_lower));
    su = longint'($signed(s.second_upper));
    ss = longint'(s.second_stride);
    // Zero or oversized strides never intersect.
    if (fs == 0 || ss == 0 || fs > MaxStride || ss > MaxStride) return r;
    if (fl <= sl) begin
      ref_lo = fl; ref_str = fs; part_lo = sl; part_str = ss;
    end else begin
      ref_lo = sl; ref_str = ss; part_lo = fl; part_str = fs;
    end
    min_up = (fu < su) ? fu : su;
    a = fs;
    b = ss;
    while (b != 0) begin
      rem = a % b;
      a = b;
      b = rem;
    end
    lcm = (fs / a) * ss;
    if (lcm > LcmLimit) return r;
    for (k = 0; k < ref_str; k++) begin
      idx = part_lo + k * part_str;
      // Past the smaller upper bound: no overlap or common element too far.
      if (idx > min_up) break;
      if ((idx - ref_lo) % ref_str == 0) begin
        top = idx + lcm * ((min_up - idx) / lcm);
        r.is_empty = 1'b0;
        r.lower    = idx[BoundW-1:0];
        r.upper    = top[BoundW-1:0];
        r.stride   = lcm[LcmW-1:0];
        return r;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure bursts while idling is on, then steady
  // ready. Only this process drives result.ready.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        result.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        result.ready <= 1'b0;
        stall_left = $urandom_range(1, 10) - 1;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    intersection_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_intersections.size() == 0) begin
        $error("unexpected result beat: is_empty=%0b lower=%0d upper=%0d stride=%0d",
               result.is_empty, result.result_lower, result.result_upper,
               result.result_stride);
        failures++;
      end else begin
        want = pending_intersections.pop_front();
        if (result.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, result.is_empty);
          failures++;
        end
        if (result.result_lower !== want.lower) begin
          $error("result_lower: expected %0d, got %0d",
                 $signed(want.lower), result.result_lower);
          failures++;
        end
        if (result.result_upper !== want.upper) begin
          $error("result_upper: expected %0d, got %0d",
                 $signed(want.upper), result.result_upper);
          failures++;
        end
        if (result.result_stride !== want.stride) begin
          $error("result_stride: expected %0d, got %0d", want.stride,
                 result.result_stride);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drive one beat from a falling edge, hold it until accepted, and record
  // the prediction at the accepting edge. Return on the next falling edge
  // with valid still high, so back-to-back beats never toggle valid.
  task automatic send_sections(input section_pair_t s);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      sections.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    sections.valid         <= 1'b1;
    sections.first_lower   <= s.first_lower;
    sections.first_upper   <= s.first_upper;
    sections.first_stride  <= s.first_stride;
    sections.second_lower  <= s.second_lower;
    sections.second_upper  <= s.second_upper;
    sections.second_stride <= s.second_stride;
    @(posedge clk);
    while (!sections.ready) @(posedge clk);
    pending_intersections.push_back(intersect_sections(s));
    @(negedge clk);
  endtask

  function automatic section_pair_t make_pair(
    logic [BoundW-1:0] fl, logic [BoundW-1:0] fu, logic [StrideW-1:0] fs,
    logic [BoundW-1:0] sl, logic [BoundW-1:0] su, logic [StrideW-1:0] ss);
    section_pair_t s;
    s.first_lower  = fl;
    s.first_upper  = fu;
    s.first_stride = fs;
    s.second_lower = sl;
    s.second_upper = su;
    s.second_stride = ss;
    return s;
  endfunction

  // Saturate a wide bound into the 32-bit signed index range.
  function automatic logic [BoundW-1:0] clamp_bound(longint v);
    longint c;
    c = (v > BoundMax) ? BoundMax : (v < BoundMin) ? BoundMin : v;
    return c[BoundW-1:0];
  endfunction

  // Mostly small strides so common elements turn up often; some up to the
  // maximum, some near it to stretch the search loop.
  function automatic logic [StrideW-1:0] pick_stride();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return StrideW'($urandom_range(1, 16));
    if (roll < 9) return StrideW'($urandom_range(1, MaxStride));
    return StrideW'($urandom_range(MaxStride - 16, MaxStride));
  endfunction

  function automatic longint pick_span();
    if ($urandom_range(0, 3) == 0) return longint'($urandom);
    return longint'($urandom_range(0, 4000));
  endfunction

  function automatic section_pair_t make_random_pair();
    section_pair_t s;
    longint        base, lo1, lo2;
    int unsigned   roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      // Nearby lower bounds anywhere in the index range: the usual overlap.
      base = longint'($signed($urandom));
      lo1 = base + longint'($urandom_range(0, 300));
      lo2 = base + longint'($urandom_range(0, 300));
      s = make_pair(clamp_bound(lo1), clamp_bound(lo1 + pick_span()), pick_stride(),
                    clamp_bound(lo2), clamp_bound(lo2 + pick_span()), pick_stride());
    end else if (roll < 75) begin
      // Raw noise: every bit free, strides include zero and oversized.
      s = make_pair($urandom, $urandom, StrideW'($urandom_range(0, 511)),
                    $urandom, $urandom, StrideW'($urandom_range(0, 511)));
    end else if (roll < 88) begin
      // Hug either end of the index range.
      if ($urandom_range(0, 1) == 0) begin
        lo1 = BoundMax - longint'($urandom_range(0, 3000));
        lo2 = BoundMax - longint'($urandom_range(0, 3000));
        s = make_pair(clamp_bound(lo1), BoundMax[BoundW-1:0], pick_stride(),
                      clamp_bound(lo2), clamp_bound(lo2 + pick_span()), pick_stride());
      end else begin
        lo1 = BoundMin + longint'($urandom_range(0, 300));
        lo2 = BoundMin + longint'($urandom_range(0, 300));
        s = make_pair(clamp_bound(lo1), clamp_bound(lo1 + pick_span()), pick_stride(),
                      clamp_bound(lo2), clamp_bound(BoundMin + pick_span()),
                      pick_stride());
      end
    end else begin
      // Broken pairs: disjoint sections, or an inverted section.
      base = longint'($signed($urandom));
      lo1 = base;
      lo2 = base + longint'($urandom_range(1, 500));
      if ($urandom_range(0, 1) == 0)
        s = make_pair(clamp_bound(lo2), clamp_bound(lo2 + pick_span()), pick_stride(),
                      clamp_bound(lo1 - 600), clamp_bound(lo1), pick_stride());
      else
        s = make_pair(clamp_bound(lo2), clamp_bound(lo1), pick_stride(),
                      clamp_bound(lo1 - 100), clamp_bound(lo2 + 100), pick_stride());
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked pairs: field extremes, both reference choices and every way
  // to end up empty.
  task automatic test_directed_cases();
    // Identical unit-stride sections.
    send_sections(make_pair(0, 10, 1, 0, 10, 1));
    // Tie on lower bounds: first section is the reference.
    send_sections(make_pair(0, 100, 4, 0, 100, 6));
    send_sections(make_pair(-7, 90, 6, -7, 100, 4));
    // Second section starts lower and becomes the reference.
    send_sections(make_pair(5, 50, 3, 2, 60, 4));
    send_sections(make_pair(-40, -3, 5, -100, 20, 7));
    // No overlap at all.
    send_sections(make_pair(0, 10, 1, 20, 30, 1));
    send_sections(make_pair(20, 30, 1, 0, 10, 1));
    // First common element would lie beyond the smaller upper bound.
    send_sections(make_pair(0, 10, 7, 3, 10, 5));
    // Partner never lands on the reference grid within the search.
    send_sections(make_pair(0, 1000, 4, 1, 1000, 2));
    send_sections(make_pair(0, 1000000000, 256, 1, 1000000000, 2));
    // Longest search that still hits, on the very last step.
    send_sections(make_pair(0, 32'h7FFF_FFFF, 256, 255, 32'h7FFF_FFFF, 255));
    // Zero stride on either side.
    send_sections(make_pair(0, 100, 0, 0, 100, 3));
    send_sections(make_pair(0, 100, 3, 0, 100, 0));
    // Strides above the maximum on either side, and the top code.
    send_sections(make_pair(0, 100, 257, 0, 100, 1));
    send_sections(make_pair(0, 100, 2, 0, 100, 9'h1FF));
    // Largest strides and largest lcm reachable.
    send_sections(make_pair(-1000, 100000, 256, -1000, 200000, 256));
    send_sections(make_pair(0, 32'h7FFF_FFFF, 256, 0, 32'h7FFF_FFFF, 255));
    // Full index range on both sides.
    send_sections(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 1,
                            32'h8000_0000, 32'h7FFF_FFFF, 1));
    send_sections(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 3,
                            32'h8000_0001, 32'h7FFF_F000, 5));
    // Single-point sections at both ends of the range.
    send_sections(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 256));
    send_sections(make_pair(32'h8000_0000, 32'h8000_0000, 256,
                            32'h8000_0000, 32'h7FFF_FFFF, 7));
    // Inverted first section: upper below lower.
    send_sections(make_pair(10, 5, 1, 0, 20, 1));
  endtask

  task automatic test_random_sections(input int unsigned count);
    repeat (count) send_sections(make_random_pair());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed cases, random with gaps and stalls, then a
  // final random stretch at full rate, drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    failures  = 0;
    idling_on = 1'b1;
    rst       = 1'b1;
    sections.valid         = 1'b0;
    sections.first_lower   = '0;
    sections.first_upper   = '0;
    sections.first_stride  = '0;
    sections.second_lower  = '0;
    sections.second_upper  = '0;
    sections.second_stride = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_random_sections(1000);
    // Last stretch runs without bubbles on either side.
    idling_on = 1'b0;
    test_random_sections(400);
    sections.valid <= 1'b0;

    // Drain, then linger past the worst-case run of one item to catch strays.
    while (pending_intersections.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
